// ----- rtl/core/bse_pkg.sv -----
// bse_pkg: types and constants shared by the lsb stego embedder
// no dependencies; imported by the rtl/core modules
`default_nettype none

package bse_pkg;

  // word operation codes on the input channel
  typedef enum logic [1:0] {
    OP_FILE    = 2'd0,
    OP_PAYLOAD = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_HEADER     = 3'd0,
    ST_EMBEDDED   = 3'd1,
    ST_NO_PAYLOAD = 3'd2,
    ST_BAD_SIG    = 3'd3,
    ST_BAD_DEPTH  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_SIG   = 2'd1,
    FAULT_DEPTH = 2'd2
  } fault_e;

  localparam logic [7:0]  SigFirst       = 8'h42;  // 'B'
  localparam logic [7:0]  SigSecond      = 8'h4D;  // 'M'
  localparam logic [31:0] OffsetFieldPos = 32'h0000_000A;
  localparam logic [31:0] DepthFieldPos  = 32'h0000_001C;
  localparam logic [31:0] HeaderMinEnd   = 32'h0000_001E;
  localparam logic [15:0] WantedDepth    = 16'd24;
  localparam logic [7:0]  KeepMask       = 8'hFC;

  // one accepted word as seen by the stream engine
  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic [7:0] data_byte;
  } step_t;

  // result produced by the stream engine for one word
  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       payload_wanted;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/bse_in_if.sv -----
// bse_in_if: input word channel (op and data byte) with valid/ready
// depends on nothing outside this file
`default_nettype none

interface bse_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bse_out_if.sv -----
// bse_out_if: result word channel (envelope byte and status) with valid/ready
// depends on nothing outside this file
`default_nettype none

interface bse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       payload_wanted;

  modport source (output valid, output out_byte, output status, output payload_wanted,
                  input ready);
  modport sink   (input valid, input out_byte, input status, input payload_wanted,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bse_engine.sv -----
// bse_engine: bmp stream state (position, header fields, fault, payload) and
// the per-word header check / bit-pair merge; depends on bse_pkg
`default_nettype none

module bse_engine (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             encode_enable_i,
  input  wire bse_pkg::step_t   step_i,
  output      bse_pkg::result_t res_o
);
  import bse_pkg::*;

  logic [31:0] pos_q, pos_d;
  logic [31:0] pds_q, pds_d;
  logic [15:0] depth_q, depth_d;
  logic [1:0]  fault_q, fault_d;
  logic [7:0]  payload_q, payload_d;
  logic        held_q, held_d;
  logic [1:0]  pair_q, pair_d;

  logic        sig_bad;
  logic [1:0]  ofs_idx;
  logic [1:0]  pair_bits;
  logic        in_header;

  always_comb begin
    pos_d     = pos_q;
    pds_d     = pds_q;
    depth_d   = depth_q;
    fault_d   = fault_q;
    payload_d = payload_q;
    held_d    = held_q;
    pair_d    = pair_q;
    res_o     = '0;
    sig_bad   = ((pos_q == 32'd0) && (step_i.data_byte != SigFirst)) ||
                ((pos_q == 32'd1) && (step_i.data_byte != SigSecond));
    ofs_idx   = pos_q[1:0] - 2'd2;
    pair_bits = 2'(payload_q >> {pair_q, 1'b0});
    in_header = 1'b0;

    if (step_i.valid) begin
      unique case (step_i.op)
        OP_PAYLOAD: begin
          payload_d = step_i.data_byte;
          held_d    = 1'b1;
          pair_d    = '0;
        end
        OP_RESTART: begin
          pos_d     = '0;
          pds_d     = '0;
          depth_d   = '0;
          fault_d   = FAULT_NONE;
          payload_d = '0;
          held_d    = 1'b0;
          pair_d    = '0;
        end
        OP_FILE: begin
          if (encode_enable_i) begin
            res_o.valid = 1'b1;
            if (fault_q != FAULT_NONE) begin
              res_o.out_byte = '0;
              res_o.status   = (fault_q == FAULT_SIG) ? ST_BAD_SIG : ST_BAD_DEPTH;
            end else begin
              if (pos_q != '1) begin
                pos_d = pos_q + 32'd1;
              end
              if (sig_bad) begin
                fault_d        = FAULT_SIG;
                res_o.out_byte = '0;
                res_o.status   = ST_BAD_SIG;
              end else begin
                // little-endian offset field, bytes 0xa..0xd
                if (pos_q >= OffsetFieldPos && pos_q < OffsetFieldPos + 32'd4) begin
                  pds_d[{ofs_idx, 3'b000} +: 8] = pds_q[{ofs_idx, 3'b000} +: 8] |
                                                  step_i.data_byte;
                end
                if (pos_q == DepthFieldPos) begin
                  depth_d[7:0] = step_i.data_byte;
                end
                if (pos_q == DepthFieldPos + 32'd1) begin
                  depth_d[15:8] = step_i.data_byte;
                end
                in_header = (pos_q < HeaderMinEnd) || (pos_q < pds_d);
                if (pos_q == DepthFieldPos + 32'd1 && depth_d != WantedDepth) begin
                  fault_d        = FAULT_DEPTH;
                  res_o.out_byte = '0;
                  res_o.status   = ST_BAD_DEPTH;
                end else if (in_header) begin
                  res_o.out_byte = step_i.data_byte;
                  res_o.status   = ST_HEADER;
                end else if (held_q) begin
                  res_o.out_byte = (step_i.data_byte & KeepMask) | {6'b0, pair_bits};
                  res_o.status   = ST_EMBEDDED;
                  pair_d         = pair_q + 2'd1;
                  if (pair_q == 2'd3) begin
                    held_d = 1'b0;
                  end
                end else begin
                  res_o.out_byte = step_i.data_byte;
                  res_o.status   = ST_NO_PAYLOAD;
                end
              end
            end
            res_o.payload_wanted = !held_d;
          end
        end
        default: begin
          // unused op code: ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      pds_q     <= '0;
      depth_q   <= '0;
      fault_q   <= FAULT_NONE;
      payload_q <= '0;
      held_q    <= 1'b0;
      pair_q    <= '0;
    end else begin
      pos_q     <= pos_d;
      pds_q     <= pds_d;
      depth_q   <= depth_d;
      fault_q   <= fault_d;
      payload_q <= payload_d;
      held_q    <= held_d;
      pair_q    <= pair_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bmp_lsb_stego_embedder_top.sv -----
// bmp_lsb_stego_embedder_top: 2-bit lsb embedder for a 24 bpp bmp byte stream
// depends on bse_pkg, bse_in_if, bse_out_if and bse_engine
//
// usage:
//   in_i carries words: op 0 is a file byte, op 1 a payload byte, op 2 restarts
//   the stream for a new file. out_o returns one word per file byte while
//   encode_enable is set: header bytes copied, pixel bytes with their two low
//   bits replaced by the next bit pair of the held payload byte or copied when
//   none is held, or a fault. payload and restart words, and file bytes while
//   encode_enable is clear, give no result. cfg_we_i/cfg_wdata_i write
//   encode_enable; write it only while no word is in flight.
// timing:
//   a word is registered at input and processed once the output register is
//   free; its result lands in the output register, which drives out_o.valid.
//   one word per cycle sustained while out_o.ready stays high; the stream
//   state is updated as each word is processed.
//   when out_o.ready is low with a result waiting, the input register holds
//   one more word, after which in_i.ready drops.
// reset:
//   rst_ni clears encode_enable, the stream state and the valid flags of both word registers.
`default_nettype none

module bmp_lsb_stego_embedder_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i,
  bse_in_if.sink    in_i,
  bse_out_if.source out_o
);
  import bse_pkg::*;

  logic       encode_enable_q;
  logic       s1_valid_q;
  logic [1:0] s1_op_q;
  logic [7:0] s1_data_q;
  logic       s1_adv;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic [2:0] status_q;
  logic       wanted_q;
  step_t      step;
  result_t    res;

  // output register frees up when empty or being taken
  assign s1_adv     = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;

  assign step.valid     = s1_valid_q && s1_adv;
  assign step.op        = s1_op_q;
  assign step.data_byte = s1_data_q;

  bse_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .encode_enable_i(encode_enable_q),
    .step_i         (step),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      encode_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      encode_enable_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= res.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_op_q   <= in_i.op;
      s1_data_q <= in_i.data_byte;
    end
    if (s1_adv && res.valid) begin
      out_byte_q <= res.out_byte;
      status_q   <= res.status;
      wanted_q   <= res.payload_wanted;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.out_byte       = out_byte_q;
  assign out_o.status         = status_q;
  assign out_o.payload_wanted = wanted_q;

  // a file word processed while enabled always lands in the output register
  a_file_word_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step.valid && s1_op_q == OP_FILE && encode_enable_q) |=> out_valid_q)
    else $error("file word processed without a result");

  // fault results never leak the cover byte
  a_fault_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == ST_BAD_SIG || status_q == ST_BAD_DEPTH)) |->
    (out_byte_q == 8'd0))
    else $error("fault result with nonzero byte");

  // a new word is never taken while both word registers are blocked
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> (!s1_valid_q || !out_valid_q || out_o.ready))
    else $error("input word accepted into a blocked pipeline");

endmodule

`default_nettype wire
